/* rtl/core/ips_pkg.sv */
package ips_pkg;

  localparam int unsigned V4_BITS   = 32;
  localparam int unsigned V6_BITS   = 128;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 64;

  localparam logic [LEN_W-1:0] PREFIX_RESET = LEN_W'(32);

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_LOOKUP_IS_IPV6 = 2'd0,
    REG_LOOKUP_ADDR_HI = 2'd1,
    REG_LOOKUP_ADDR_LO = 2'd2,
    REG_PREFIX_LENGTH  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]  interface_index;
    logic              is_up;
    logic              is_loopback;
    logic              is_multicast;
    logic              entry_is_ipv6;
    logic [WORD_W-1:0] entry_addr_hi;
    logic [WORD_W-1:0] entry_addr_lo;
    logic [WORD_W-1:0] entry_mask_hi;
    logic [WORD_W-1:0] entry_mask_lo;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic              chosen_is_ipv6;
    logic [WORD_W-1:0] chosen_addr_hi;
    logic [WORD_W-1:0] chosen_addr_lo;
    logic [IDX_W-1:0]  chosen_index;
    logic [LEN_W-1:0]  best_length;
  } out_item_t;

  typedef struct packed {
    logic              lookup_is_ipv6;
    logic [WORD_W-1:0] lookup_addr_hi;
    logic [WORD_W-1:0] lookup_addr_lo;
    logic [LEN_W-1:0]  prefix_length;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic              is_ipv6;
    logic [WORD_W-1:0] addr_hi;
    logic [WORD_W-1:0] addr_lo;
    logic [IDX_W-1:0]  index;
  } sel_state_t;

endpackage

/* rtl/core/ips_cfg.sv */
module ips_cfg import ips_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  reg_idx_t sel_idx;
  logic     wr_en;

  assign sel_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lookup_is_ipv6 <= 1'b0;
      cfg_r.lookup_addr_hi <= '0;
      cfg_r.lookup_addr_lo <= '0;
      cfg_r.prefix_length  <= PREFIX_RESET;
    end else if (wr_en) begin
      case (sel_idx)
        REG_LOOKUP_IS_IPV6: cfg_r.lookup_is_ipv6 <= pwdata[0];
        REG_LOOKUP_ADDR_HI: cfg_r.lookup_addr_hi <= pwdata;
        REG_LOOKUP_ADDR_LO: cfg_r.lookup_addr_lo <= pwdata;
        REG_PREFIX_LENGTH:  cfg_r.prefix_length  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_idx)
      REG_LOOKUP_IS_IPV6: prdata = {{(PDATA_W-1){1'b0}}, cfg_r.lookup_is_ipv6};
      REG_LOOKUP_ADDR_HI: prdata = cfg_r.lookup_addr_hi;
      REG_LOOKUP_ADDR_LO: prdata = cfg_r.lookup_addr_lo;
      REG_PREFIX_LENGTH:  prdata = {{(PDATA_W-LEN_W){1'b0}}, cfg_r.prefix_length};
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/core/ips_match.sv */
module ips_match import ips_pkg::*; (
  input  cfg_t       cfg,
  input  in_item_t   item,
  input  sel_state_t cur,
  output sel_state_t nxt,
  output logic       accepted
);

  localparam int unsigned NBYTES = V6_BITS / 8;

  logic [LEN_W-1:0]   p6;
  logic [5:0]         p4;
  logic [V6_BITS-1:0] mask6;
  logic [V4_BITS-1:0] mask4;
  logic [V6_BITS-1:0] diff6;
  logic [V4_BITS-1:0] diff4;
  logic               agrees;
  logic               consider;
  logic [V6_BITS-1:0] cnt_src;
  logic [3:0]         lvl0 [NBYTES];
  logic [4:0]         lvl1 [NBYTES/2];
  logic [5:0]         lvl2 [NBYTES/4];
  logic [6:0]         lvl3 [NBYTES/8];
  logic [LEN_W-1:0]   len;
  logic               take;

  // clamp prefix to the family width
  assign p6 = (cfg.prefix_length > LEN_W'(V6_BITS)) ? LEN_W'(V6_BITS) : cfg.prefix_length;
  assign p4 = (cfg.prefix_length > LEN_W'(V4_BITS)) ? 6'(V4_BITS)
                                                    : cfg.prefix_length[5:0];

  assign mask6 = ~({V6_BITS{1'b1}} >> p6);
  assign mask4 = ~({V4_BITS{1'b1}} >> p4);

  assign diff6 = {item.entry_addr_hi, item.entry_addr_lo}
               ^ {cfg.lookup_addr_hi, cfg.lookup_addr_lo};
  assign diff4 = item.entry_addr_lo[V4_BITS-1:0] ^ cfg.lookup_addr_lo[V4_BITS-1:0];

  assign agrees = item.entry_is_ipv6 ? ((diff6 & mask6) == '0)
                                     : ((diff4 & mask4) == '0);

  assign consider = item.is_up && (item.entry_is_ipv6 == cfg.lookup_is_ipv6) && agrees;

  // netmask popcount, ipv4 counts the low 32 bits only
  assign cnt_src = item.entry_is_ipv6
                 ? {item.entry_mask_hi, item.entry_mask_lo}
                 : {{(V6_BITS-V4_BITS){1'b0}}, item.entry_mask_lo[V4_BITS-1:0]};

  always_comb begin
    for (int b = 0; b < NBYTES; b++) begin
      lvl0[b] = '0;
      for (int k = 0; k < 8; k++) begin
        lvl0[b] = lvl0[b] + {3'b0, cnt_src[b*8+k]};
      end
    end
    for (int i = 0; i < NBYTES/2; i++) begin
      lvl1[i] = {1'b0, lvl0[2*i]} + {1'b0, lvl0[2*i+1]};
    end
    for (int i = 0; i < NBYTES/4; i++) begin
      lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    for (int i = 0; i < NBYTES/8; i++) begin
      lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    end
    len = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
  end

  always_comb begin
    nxt      = cur;
    accepted = 1'b0;
    take     = 1'b0;
    if (consider && item.is_loopback && !cur.found) begin
      take      = 1'b1;
      nxt.found = 1'b1;
      accepted  = 1'b1;
    end else if (consider && item.is_multicast) begin
      if (len > cur.best_len) begin
        take         = 1'b1;
        nxt.best_len = len;
      end
      nxt.found = 1'b1;
      accepted  = 1'b1;
    end
    if (take) begin
      nxt.is_ipv6 = item.entry_is_ipv6;
      nxt.addr_hi = item.entry_is_ipv6 ? item.entry_addr_hi : '0;
      nxt.addr_lo = item.entry_is_ipv6 ? item.entry_addr_lo
                  : {{(WORD_W-V4_BITS){1'b0}}, item.entry_addr_lo[V4_BITS-1:0]};
      nxt.index   = item.interface_index;
    end
  end

endmodule

/* rtl/core/interface_prefix_selector.sv */
// interface prefix selector
//
// each request on the in_ channel is one interface entry; the block checks it
// against the lookup address and prefix length held in the apb registers and
// updates the running selection (found flag, chosen address, index, best
// netmask length). every request yields exactly one result on the out_
// channel carrying the accept flag and the selection after that entry.
//
// one input register, then prefix compare, mask popcount and select logic feed
// the result register and the selection state in the same cycle. out_valid
// rises when the result register loads. throughput is one entry per cycle
// while the result slot is free, set by the loop through the selection state.
//
// when out_ready is low the result register holds and one more request is taken
// into the input register, after which in_ready drops until the result is taken.
// a synchronous reset (rst_n low) clears the selection, starting a new lookup,
// and restores the registers (prefix length back to 32). the user must write
// configuration through the apb port while no request is in flight (unchecked).
module interface_prefix_selector import ips_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg;
  in_item_t   in_data_r;
  logic       in_valid_r;
  out_item_t  out_data_r;
  logic       out_valid_r;
  sel_state_t state_r;
  sel_state_t state_nxt;
  logic       accepted;
  logic       advance;

  ips_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ips_match u_match (
    .cfg      (cfg),
    .item     (in_data_r),
    .cur      (state_r),
    .nxt      (state_nxt),
    .accepted (accepted)
  );

  // entry in the input register moves on when the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.accepted       <= accepted;
      out_data_r.found          <= state_nxt.found;
      out_data_r.chosen_is_ipv6 <= state_nxt.is_ipv6;
      out_data_r.chosen_addr_hi <= state_nxt.addr_hi;
      out_data_r.chosen_addr_lo <= state_nxt.addr_lo;
      out_data_r.chosen_index   <= state_nxt.index;
      out_data_r.best_length    <= state_nxt.best_len;
    end
  end

endmodule
